// File: rtl/battery_voltage_monitor_assert.svh
// ----------------------------------------------------------------------------
// Battery voltage monitor assertion macros
// Shorthand for the concurrent checks at the end of the top level. The
// module that takes this header provides clock and reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_MONITOR_ASSERT_SVH
`define BATTERY_VOLTAGE_MONITOR_ASSERT_SVH

// cons must hold in the same cycle as ante
`define BVM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define BVM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor package
// Beat types, register map, divider interface and fixed-point constants.
// ----------------------------------------------------------------------------
package bvm_pkg;

   localparam int AdcWidth     = 12;
   localparam int TimeWidth    = 32;
   localparam int CvWidth      = 14;
   localparam int ScaleWidth   = 24;
   localparam int BrightWidth  = 8;
   localparam int PixWidth     = 6;
   localparam int IvalWidth    = 16;
   localparam int TotalWidth   = 16;
   localparam int MaxPixels    = 32;

   localparam int CsrAddrWidth = 5;
   localparam int CsrDataWidth = 32;

   // register reset values
   localparam logic [CvWidth-1:0]     MinCvReset     = 14'd3300;
   localparam logic [CvWidth-1:0]     MaxCvReset     = 14'd4200;
   localparam logic [ScaleWidth-1:0]  VoltScaleReset = 24'd131072;
   localparam logic [BrightWidth-1:0] MaxBrightReset = 8'd255;
   localparam logic [PixWidth-1:0]    PixCountReset  = 6'd8;
   localparam logic [IvalWidth-1:0]   CheckIvalReset = 16'd300;
   localparam logic [IvalWidth-1:0]   WarnIvalReset  = 16'd5000;

   // floor(r / 10) = (r * DecRecip) >> DecShift, exact for 14-bit r
   localparam int                     DecShift  = 18;
   localparam logic [14:0]            DecRecip  = 15'd26215;
   // floor(x / 100) = (x * PctRecip) >> PctShift, exact for x <= 99 * 255
   localparam int                     PctShift  = 19;
   localparam logic [12:0]            PctRecip  = 13'd5243;
   localparam logic [6:0]             PctScale  = 7'd100;

   // shared divider: quotient below 2^DivSteps, one bit per cycle
   localparam int DivSteps    = 7;
   localparam int DivNumWidth = 21;
   localparam int DivDenWidth = CvWidth;

   typedef enum logic [2:0] {
      CsrMinCv      = 3'd0,
      CsrMaxCv      = 3'd1,
      CsrVoltScale  = 3'd2,
      CsrMaxBright  = 3'd3,
      CsrPixelCount = 3'd4,
      CsrCheckIval  = 3'd5,
      CsrWarnIval   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [AdcWidth-1:0]  adc_sample;
      logic [TimeWidth-1:0] now_ms;
   } bvm_req_type;

   typedef struct packed {
      logic                   checked;
      logic                   alarm;
      logic                   warn_beep;
      logic [AdcWidth-1:0]    average_adc;
      logic [CvWidth-1:0]     centivolts;
      logic [PixWidth-1:0]    full_pixels;
      logic [BrightWidth-1:0] partial_green;
      logic                   all_red;
   } bvm_rsp_type;

   typedef struct packed {
      logic                   start;
      logic [DivNumWidth-1:0] dividend;
      logic [DivDenWidth-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [DivSteps-1:0]    quotient;
      logic [DivDenWidth-1:0] remainder;
   } div_rsp_type;

endpackage

// File: rtl/bvm_div.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor divider
// Restoring divider, one quotient bit per cycle; done pulses for one cycle
// once the last quotient bit is in. Caller keeps the quotient below 2^DivSteps.
// ----------------------------------------------------------------------------
module bvm_div
   import bvm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CntWidth = $clog2(DivSteps);

   logic [DivNumWidth-1:0] rem_ff, rem_in;
   logic [DivNumWidth-1:0] den_ff, den_in;
   logic [DivSteps-1:0]    quot_ff, quot_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DivNumWidth:0]   trial;

   assign trial = {1'b0, rem_ff} - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         den_in  = DivNumWidth'({div_req.divisor, {(DivSteps-1){1'b0}}});
         quot_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DivNumWidth]) begin
            rem_in  = trial[DivNumWidth-1:0];
            quot_in = {quot_ff[DivSteps-2:0], 1'b1};
         end else begin
            quot_in = {quot_ff[DivSteps-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quot_ff;
   assign div_rsp.remainder = rem_ff[DivDenWidth-1:0];

endmodule

// File: rtl/battery_voltage_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage monitor
// Moving average of converter samples, scaled to centivolts, with limit
// alarm, rate-limited low warning and bar-graph level.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                      beat
//   req_     in         req_valid / req_stall          adc_sample, now_ms
//   rsp_     out        rsp_valid / rsp_stall          one result per req beat
//   csr      in/out     psel, penable, pwrite, pready  32-bit register access
//
// A req beat is taken only while the sequencer is idle. An ignored beat
// (check interval not passed) goes from S_READ straight to S_DONE; a checked
// beat passes S_AVG, S_SCALE, S_EVAL and S_BAR, and one with a partial pixel
// also waits in S_DIV1 and S_DIV2 on two 7-step divides in the shared divider.
// The result sits in an output register; a stalled rsp holds it while the
// next req beat is already taken and worked on.
// Synchronous reset clears the ring valid bits, so no clearing pass.
//
`include "battery_voltage_monitor_assert.svh"

module battery_voltage_monitor
   import bvm_pkg::*;
#(
   parameter int WINDOW = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bvm_req_type             req_data,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bvm_rsp_type             rsp_data,
   // register port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CsrAddrWidth-1:0] paddr,
   input  logic [CsrDataWidth-1:0] pwdata,
   output logic [CsrDataWidth-1:0] prdata,
   output logic                    pready
);

   // ring index and exact reciprocal of WINDOW for 16-bit totals
   localparam int RingAw   = $clog2(WINDOW);
   localparam int AvgShift = TotalWidth + $clog2(WINDOW);
   localparam logic [TotalWidth:0] AvgRecip =
      (TotalWidth+1)'(((64'd1 << AvgShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_AVG,
      S_SCALE,
      S_EVAL,
      S_BAR,
      S_DIV1,
      S_DIV2,
      S_GREEN,
      S_DONE
   } state_type;

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   state_type              state_ff, state_in;

   // configuration
   logic [CvWidth-1:0]     min_cv_ff, min_cv_in;
   logic [CvWidth-1:0]     max_cv_ff, max_cv_in;
   logic [ScaleWidth-1:0]  scale_ff, scale_in;
   logic [BrightWidth-1:0] bright_ff, bright_in;
   logic [PixWidth-1:0]    pix_cnt_ff, pix_cnt_in;
   logic [IvalWidth-1:0]   chk_ival_ff, chk_ival_in;
   logic [IvalWidth-1:0]   warn_ival_ff, warn_ival_in;

   // running state
   logic [TotalWidth-1:0]  total_ff, total_in;
   logic [RingAw-1:0]      pos_ff, pos_in;
   logic [TimeWidth-1:0]   last_chk_ff, last_chk_in;
   logic [TimeWidth-1:0]   last_warn_ff, last_warn_in;
   logic [WINDOW-1:0]      ring_vld_ff, ring_vld_in;

   // current beat and datapath
   logic [AdcWidth-1:0]    sample_ff, sample_in;
   logic [TimeWidth-1:0]   now_ff, now_in;
   logic                   skip_ff, skip_in;
   logic [AdcWidth-1:0]    avg_ff, avg_in;
   logic [10:0]            tenth_ff, tenth_in;
   logic [CvWidth-1:0]     cv_ff, cv_in;
   logic [19:0]            sat_lim_ff, sat_lim_in;
   logic [19:0]            prod_ff, prod_in;
   logic                   below_ff, below_in;
   logic                   alarm_ff, alarm_in;
   logic                   warn_ff, warn_in;
   logic [PixWidth-1:0]    full_ff, full_in;
   logic [14:0]            gp_ff, gp_in;
   logic [BrightWidth-1:0] green_ff, green_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   bvm_rsp_type            rsp_data_ff, rsp_data_in;

   // sample ring
   logic [AdcWidth-1:0]    ring_mem [WINDOW];
   logic [AdcWidth-1:0]    rd_data_ff;
   logic                   ring_we;

   // ------------------------------------------------------------------------
   // Datapath terms
   // ------------------------------------------------------------------------
   logic [PixWidth-1:0]    pixels;
   logic [CvWidth-1:0]     range_u;
   logic                   flat;
   logic [TimeWidth-1:0]   elapsed_chk;
   logic                   skip_calc;
   logic [AdcWidth-1:0]    old_sample;
   logic [TotalWidth-1:0]  total_next;
   logic [2*TotalWidth:0]  avg_prod;
   logic [28:0]            tenth_prod;
   logic [35:0]            scaled;
   logic [CvWidth-1:0]     cv_sat;
   logic [19:0]            sat_prod;
   logic [14:0]            warn_level;
   logic [TimeWidth-1:0]   elapsed_warn;
   logic                   warn_due;
   logic                   cv_low;
   logic                   cv_high;
   logic                   warn_calc;
   logic [CvWidth-1:0]     diff;
   logic [19:0]            prod_calc;
   logic [DivNumWidth-1:0] rem100;
   logic [14:0]            gp_calc;
   logic [27:0]            green_prod;
   logic                   bar_sat;
   logic                   rsp_load;
   logic                   cfg_write;
   csr_index_type          csr_idx;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // pixel count clamps to what the bar can hold
   assign pixels  = (pix_cnt_ff > PixWidth'(MaxPixels)) ? PixWidth'(MaxPixels) : pix_cnt_ff;
   assign range_u = max_cv_ff - min_cv_ff;
   assign flat    = (max_cv_ff <= min_cv_ff);

   // interval check on the incoming beat, modulo 2^32
   assign elapsed_chk = req_data.now_ms - last_chk_ff;
   assign skip_calc   = (elapsed_chk < TimeWidth'(chk_ival_ff));

   // running total: drop the oldest entry, add the new sample
   assign old_sample = ring_vld_ff[pos_ff] ? rd_data_ff : '0;
   assign total_next = total_ff - TotalWidth'(old_sample) + TotalWidth'(sample_ff);

   assign avg_prod   = (2*TotalWidth+1)'(total_ff) * (2*TotalWidth+1)'(AvgRecip);
   assign tenth_prod = 29'(range_u) * 29'(DecRecip);

   // Q16 scale, saturate to 14 bits
   assign scaled = 36'(avg_ff) * 36'(scale_ff);
   assign cv_sat = (|scaled[35:30]) ? '1 : scaled[29:16];

   // saturation point of the bar: pixels * range
   assign sat_prod = 20'(pixels) * 20'(range_u);

   assign warn_level   = 15'(min_cv_ff) + 15'(tenth_ff);
   assign elapsed_warn = now_ff - last_warn_ff;
   assign warn_due     = (elapsed_warn > TimeWidth'(warn_ival_ff));
   assign cv_low       = (cv_ff < min_cv_ff);
   assign cv_high      = (cv_ff > max_cv_ff);
   // warning only inside the limits, so range is never negative here
   assign warn_calc    = !cv_low && !cv_high && (15'(cv_ff) < warn_level) && warn_due;

   assign diff      = cv_ff - min_cv_ff;
   assign prod_calc = 20'(diff) * 20'(pixels);
   assign bar_sat   = flat || (prod_ff >= sat_lim_ff);

   assign rem100     = DivNumWidth'(div_rsp.remainder) * DivNumWidth'(PctScale);
   assign gp_calc    = 15'(div_rsp.quotient) * 15'(bright_ff);
   assign green_prod = 28'(gp_ff) * 28'(PctRecip);

   // ------------------------------------------------------------------------
   // Shared divider: prod / range, then remainder * 100 / range
   // ------------------------------------------------------------------------
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = DivNumWidth'(prod_ff);
      div_req.divisor  = range_u;
      if (state_ff == S_BAR) begin
         div_req.start = !below_ff && !bar_sat;
      end else if (state_ff == S_DIV1) begin
         div_req.start    = div_rsp.done;
         div_req.dividend = rem100;
      end
   end

   bvm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign csr_idx   = csr_index_type'(paddr[CsrAddrWidth-1:2]);

   always_comb begin
      case (csr_idx)
         CsrMinCv:      prdata = CsrDataWidth'(min_cv_ff);
         CsrMaxCv:      prdata = CsrDataWidth'(max_cv_ff);
         CsrVoltScale:  prdata = CsrDataWidth'(scale_ff);
         CsrMaxBright:  prdata = CsrDataWidth'(bright_ff);
         CsrPixelCount: prdata = CsrDataWidth'(pix_cnt_ff);
         CsrCheckIval:  prdata = CsrDataWidth'(chk_ival_ff);
         CsrWarnIval:   prdata = CsrDataWidth'(warn_ival_ff);
         default:       prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      min_cv_in    = min_cv_ff;
      max_cv_in    = max_cv_ff;
      scale_in     = scale_ff;
      bright_in    = bright_ff;
      pix_cnt_in   = pix_cnt_ff;
      chk_ival_in  = chk_ival_ff;
      warn_ival_in = warn_ival_ff;
      total_in     = total_ff;
      pos_in       = pos_ff;
      last_chk_in  = last_chk_ff;
      last_warn_in = last_warn_ff;
      ring_vld_in  = ring_vld_ff;
      sample_in    = sample_ff;
      now_in       = now_ff;
      skip_in      = skip_ff;
      avg_in       = avg_ff;
      tenth_in     = tenth_ff;
      cv_in        = cv_ff;
      sat_lim_in   = sat_lim_ff;
      prod_in      = prod_ff;
      below_in     = below_ff;
      alarm_in     = alarm_ff;
      warn_in      = warn_ff;
      full_in      = full_ff;
      gp_in        = gp_ff;
      green_in     = green_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ring_we      = 1'b0;

      if (cfg_write) begin
         case (csr_idx)
            CsrMinCv:      min_cv_in    = pwdata[CvWidth-1:0];
            CsrMaxCv:      max_cv_in    = pwdata[CvWidth-1:0];
            CsrVoltScale:  scale_in     = pwdata[ScaleWidth-1:0];
            CsrMaxBright:  bright_in    = pwdata[BrightWidth-1:0];
            CsrPixelCount: pix_cnt_in   = pwdata[PixWidth-1:0];
            CsrCheckIval:  chk_ival_in  = pwdata[IvalWidth-1:0];
            CsrWarnIval:   warn_ival_in = pwdata[IvalWidth-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            // ring read for the current position is issued on this edge too
            if (req_valid) begin
               sample_in = req_data.adc_sample;
               now_in    = req_data.now_ms;
               skip_in   = skip_calc;
               state_in  = S_READ;
            end
         end
         S_READ: begin
            if (skip_ff) begin
               state_in = S_DONE;
            end else begin
               total_in            = total_next;
               ring_we             = 1'b1;
               ring_vld_in[pos_ff] = 1'b1;
               pos_in              = (pos_ff == RingAw'(WINDOW - 1)) ? '0 : pos_ff + 1'b1;
               last_chk_in         = now_ff;
               state_in            = S_AVG;
            end
         end
         S_AVG: begin
            avg_in   = AdcWidth'(avg_prod >> AvgShift);
            tenth_in = 11'(tenth_prod >> DecShift);
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cv_in      = cv_sat;
            sat_lim_in = sat_prod;
            state_in   = S_EVAL;
         end
         S_EVAL: begin
            alarm_in = cv_low || cv_high;
            below_in = cv_low;
            warn_in  = warn_calc;
            if (warn_calc) begin
               last_warn_in = now_ff;
            end
            prod_in  = prod_calc;
            full_in  = '0;
            green_in = '0;
            state_in = S_BAR;
         end
         S_BAR: begin
            if (below_ff) begin
               state_in = S_DONE;
            end else if (bar_sat) begin
               full_in  = pixels;
               state_in = S_DONE;
            end else begin
               state_in = S_DIV1;
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               full_in  = PixWidth'(div_rsp.quotient);
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               gp_in    = gp_calc;
               state_in = S_GREEN;
            end
         end
         S_GREEN: begin
            green_in = BrightWidth'(green_prod >> PctShift);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.checked       = 1'b1;
               rsp_data_in.alarm         = alarm_ff;
               rsp_data_in.warn_beep     = warn_ff;
               rsp_data_in.average_adc   = avg_ff;
               rsp_data_in.centivolts    = cv_ff;
               rsp_data_in.full_pixels   = full_ff;
               rsp_data_in.partial_green = green_ff;
               rsp_data_in.all_red       = below_ff;
               // ignored beat: every field zero
               if (skip_ff) begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      now_ff      <= now_in;
      skip_ff     <= skip_in;
      avg_ff      <= avg_in;
      tenth_ff    <= tenth_in;
      cv_ff       <= cv_in;
      sat_lim_ff  <= sat_lim_in;
      prod_ff     <= prod_in;
      below_ff    <= below_in;
      alarm_ff    <= alarm_in;
      warn_ff     <= warn_in;
      full_ff     <= full_in;
      gp_ff       <= gp_in;
      green_ff    <= green_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         min_cv_ff    <= MinCvReset;
         max_cv_ff    <= MaxCvReset;
         scale_ff     <= VoltScaleReset;
         bright_ff    <= MaxBrightReset;
         pix_cnt_ff   <= PixCountReset;
         chk_ival_ff  <= CheckIvalReset;
         warn_ival_ff <= WarnIvalReset;
         total_ff     <= '0;
         pos_ff       <= '0;
         last_chk_ff  <= '0;
         last_warn_ff <= '0;
         ring_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_cv_ff    <= min_cv_in;
         max_cv_ff    <= max_cv_in;
         scale_ff     <= scale_in;
         bright_ff    <= bright_in;
         pix_cnt_ff   <= pix_cnt_in;
         chk_ival_ff  <= chk_ival_in;
         warn_ival_ff <= warn_ival_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         last_chk_ff  <= last_chk_in;
         last_warn_ff <= last_warn_in;
         ring_vld_ff  <= ring_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sample ring: one write, one registered read at the ring position
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[pos_ff] <= sample_ff;
      end
      rd_data_ff <= ring_mem[pos_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `BVM_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, state_ff == S_READ, "accepted beat did not start the sequencer")
   `BVM_ASSERT_NEXT(a_skip_keeps_ring, state_ff == S_READ && skip_ff, $stable(total_ff) && $stable(pos_ff) && $stable(last_chk_ff), "ignored beat changed the ring state")
   `BVM_ASSERT_NOW(a_div_done_waited, div_rsp.done, state_ff == S_DIV1 || state_ff == S_DIV2, "divider finished outside a wait state")
   `BVM_ASSERT_NEXT(a_load_checked, rsp_load, rsp_valid && (rsp_data.checked == !$past(skip_ff)), "result checked flag does not match the interval test")
   `BVM_ASSERT_NOW(a_red_is_alarm, rsp_valid && rsp_data.all_red, rsp_data.alarm && (rsp_data.full_pixels == '0) && (rsp_data.partial_green == '0), "all red result without alarm or with lit bar")

endmodule
